// ----- design/pmd_pkg.sv -----
package pmd_pkg;

   localparam int QUEUE_DEPTH = 4;

   // event kinds
   localparam logic EV_MOTION = 1'b0;
   localparam logic EV_BUTTON = 1'b1;

   // event codes
   localparam logic [1:0] CODE_X      = 2'd0;
   localparam logic [1:0] CODE_Y      = 2'd1;
   localparam logic [1:0] CODE_LEFT   = 2'd0;
   localparam logic [1:0] CODE_RIGHT  = 2'd1;
   localparam logic [1:0] CODE_MIDDLE = 2'd2;

   // header byte fields
   localparam int SYNC_BIT = 3;
   localparam int OVF_X_BIT = 6;
   localparam int OVF_Y_BIT = 7;

   // bit positions in the pending-event mask, in output order
   localparam int EVB_X      = 0;
   localparam int EVB_Y      = 1;
   localparam int EVB_LEFT   = 2;
   localparam int EVB_RIGHT  = 3;
   localparam int EVB_MIDDLE = 4;
   localparam int NUM_EVENTS = 5;

   typedef struct packed {
      logic [NUM_EVENTS-1:0] mask;
      logic [8:0]            dx;
      logic [8:0]            dy;
      logic [2:0]            buttons;
   } pmd_pkt_type;

endpackage

// ----- design/pmd_queue.sv -----
module pmd_queue
   import pmd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH,
   parameter int WIDTH = $bits(pmd_pkt_type)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CntW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("queue pop while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

// ----- design/pmd_front.sv -----
module pmd_front
   import pmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        q_full,
   output logic        q_push,
   output pmd_pkt_type q_data
);

   typedef enum logic [1:0] {
      POS_HEADER,
      POS_X,
      POS_Y
   } pos_type;

   pos_type     pos_ff, pos_in;
   logic        enabled_ff, enabled_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  x_byte_ff, x_byte_in;
   logic [2:0]  prev_btn_ff, prev_btn_in;
   logic        take;
   logic        ovf;
   pmd_pkt_type pkt;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready && enabled_ff;

   assign ovf = header_ff[OVF_X_BIT] || header_ff[OVF_Y_BIT];

   always_comb begin
      pkt.buttons            = header_ff[2:0];
      pkt.dx                 = {x_byte_ff[7], x_byte_ff};
      pkt.dy                 = 9'(9'd0 - {req_tdata[7], req_tdata});
      pkt.mask[EVB_X]        = !ovf && (x_byte_ff != 8'd0);
      pkt.mask[EVB_Y]        = !ovf && (req_tdata != 8'd0);
      pkt.mask[EVB_MIDDLE:EVB_LEFT] = header_ff[2:0] ^ prev_btn_ff;
   end

   assign q_data = pkt;
   assign q_push = take && (pos_ff == POS_Y) && (pkt.mask != '0);

   always_comb begin
      pos_in      = pos_ff;
      header_in   = header_ff;
      x_byte_in   = x_byte_ff;
      prev_btn_in = prev_btn_ff;
      enabled_in  = csr_valid ? csr_data : enabled_ff;
      if (take) begin
         unique case (pos_ff)
            POS_X: begin
               x_byte_in = req_tdata;
               pos_in    = POS_Y;
            end
            POS_Y: begin
               prev_btn_in = header_ff[2:0];
               pos_in      = POS_HEADER;
            end
            default: begin
               // resync: wait for a byte with the always-one bit set
               if (req_tdata[SYNC_BIT]) begin
                  header_in = req_tdata;
                  pos_in    = POS_X;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_HEADER;
         enabled_ff  <= 1'b0;
         prev_btn_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         enabled_ff  <= enabled_in;
         prev_btn_ff <= prev_btn_in;
         header_ff   <= header_in;
         x_byte_ff   <= x_byte_in;
      end
   end

   a_pkt_ends: assert property (@(posedge clock) disable iff (reset)
      (take && pos_ff == POS_Y) |=> (pos_ff == POS_HEADER))
      else $error("packet did not end after third byte");

   a_push_on_y: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (pos_ff == POS_Y && enabled_ff))
      else $error("push outside third byte");

   a_btn_kept: assert property (@(posedge clock) disable iff (reset)
      (take && pos_ff == POS_Y) |=> (prev_btn_ff == $past(header_ff[2:0])))
      else $error("button state not updated");

endmodule

// ----- design/pmd_back.sv -----
module pmd_back
   import pmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  pmd_pkt_type q_data,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic                  busy_ff, busy_in;
   logic [NUM_EVENTS-1:0] pend_ff, pend_in;
   pmd_pkt_type           pkt_ff, pkt_in;
   logic                  out_vld_ff, out_vld_in;
   logic                  kind_ff, kind_in;
   logic [1:0]            code_ff, code_in;
   logic [8:0]            value_ff, value_in;
   logic                  last_ff, last_in;
   logic [NUM_EVENTS-1:0] pend_next;
   logic                  out_free;
   logic                  emit;
   logic                  done;

   assign out_free  = !out_vld_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   // clear the lowest pending event
   assign pend_next = pend_ff & (pend_ff - 1'b1);
   assign done      = emit && (pend_next == '0);
   assign q_pop     = q_not_empty && (!busy_ff || done);

   always_comb begin
      kind_in  = EV_BUTTON;
      code_in  = CODE_LEFT;
      value_in = {8'd0, pkt_ff.buttons[0]};
      priority case (1'b1)
         pend_ff[EVB_X]: begin
            kind_in  = EV_MOTION;
            code_in  = CODE_X;
            value_in = pkt_ff.dx;
         end
         pend_ff[EVB_Y]: begin
            kind_in  = EV_MOTION;
            code_in  = CODE_Y;
            value_in = pkt_ff.dy;
         end
         pend_ff[EVB_LEFT]: begin
            code_in  = CODE_LEFT;
            value_in = {8'd0, pkt_ff.buttons[0]};
         end
         pend_ff[EVB_RIGHT]: begin
            code_in  = CODE_RIGHT;
            value_in = {8'd0, pkt_ff.buttons[1]};
         end
         default: begin
            code_in  = CODE_MIDDLE;
            value_in = {8'd0, pkt_ff.buttons[2]};
         end
      endcase
      last_in = (pend_next == '0);

      out_vld_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

      busy_in = busy_ff;
      pend_in = pend_ff;
      pkt_in  = pkt_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         pend_in = q_data.mask;
         pkt_in  = q_data;
      end else if (done) begin
         busy_in = 1'b0;
         pend_in = '0;
      end else if (emit) begin
         pend_in = pend_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         pend_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
         pkt_ff     <= pkt_in;
         if (emit) begin
            kind_ff  <= kind_in;
            code_ff  <= code_in;
            value_ff <= value_in;
            last_ff  <= last_in;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {5'd0, value_ff, code_ff};
   assign rsp_tlast  = last_ff;

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pend_ff != '0))
      else $error("busy with no pending event");

   a_emit_fills_out: assert property (@(posedge clock) disable iff (reset)
      emit |=> out_vld_ff)
      else $error("emitted event lost");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!busy_ff || done))
      else $error("pop while packet in flight");

endmodule

// ----- design/ps2_mouse_packet_decoder.sv -----
// PS/2 mouse packet decoder. Raw mouse bytes come in on req_*, one per
// transaction; the block syncs on a header byte with bit 3 set, collects the
// X and Y bytes, and on the third byte queues the packet's events. Events go
// out on rsp_* in the order X, Y, left, right, middle, one per cycle while
// rsp_tready is high, with tlast on the final event of a packet; zero motion,
// overflowed motion and unchanged buttons give no event, so a packet yields
// zero to five events. Bytes are accepted every cycle while the packet queue
// (QueueDepth entries) has room; the event sequencer behind it drains one
// event per cycle while rsp_tready is high, taking the next packet from the
// queue as the last event of the current one goes out; the queue absorbs bursts.
// While csr enabled is 0 every byte taken is dropped without state change.
module ps2_mouse_packet_decoder
   import pmd_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,     // enabled
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [1:0] event_code, [10:2] event_value, rest zero
   output logic        rsp_tuser,    // event_kind
   output logic        rsp_tlast
);

   localparam int PktW = $bits(pmd_pkt_type);

   logic        q_full;
   logic        q_push;
   logic        q_pop;
   logic        q_not_empty;
   pmd_pkt_type q_wdata;
   pmd_pkt_type q_rdata;

   pmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   pmd_queue #(
      .DEPTH (QueueDepth),
      .WIDTH (PktW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .not_empty (q_not_empty)
   );

   pmd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
